// File: rtl/ypcb_pkg.sv
`timescale 1ns / 1ps
// ypcb_pkg: shared constants, types and rounding helpers for the camera basis block
// used by ypcb_lane, ypcb_merge and yaw_pitch_camera_basis; depends on nothing

package ypcb_pkg;

    // number formats
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int VEC_FRAC_BITS   = 14;
    localparam int ANGLE_W         = 17;
    localparam int FIELD_W         = 16;
    localparam int VEC_W           = VEC_FRAC_BITS + 2;

    // cordic datapath
    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_ZFRAC = 24;
    localparam int CORDIC_XFRAC = 30;
    localparam int CW           = 32;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // arctangent of 2^-i in Q24 degrees
    localparam logic signed [CW-1:0] ATAN_DEG_Q24 [CORDIC_ITERS] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    // angle reduction
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
    localparam int IN_SPAN      = 1 << (ANGLE_W - 1);
    localparam int OFS_TURNS    = (IN_SPAN + FULL_TURN - 1) / FULL_TURN;
    localparam int MAX_TURNS    = (IN_SPAN - 1 + OFS_TURNS * FULL_TURN) / FULL_TURN;
    localparam int SHIFT_W      = $clog2(IN_SPAN + OFS_TURNS * FULL_TURN);
    localparam int TURN_W       = $clog2(FULL_TURN);
    localparam int QTR_W        = $clog2(QUARTER_TURN);
    localparam int QUAD_W       = 2;

    // quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    // rounding shifts
    localparam int CORDIC_SH  = CORDIC_XFRAC - VEC_FRAC_BITS;
    localparam int CORDIC_RND = (CORDIC_SH == 0) ? 0 : (1 << (CORDIC_SH - 1));
    localparam int PROD_W     = 2 * VEC_W;
    localparam int PROD_RND   = 1 << (VEC_FRAC_BITS - 1);

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_vec VEC_ONE = t_vec'(1) <<< VEC_FRAC_BITS;

    // sine and cosine of one angle
    typedef struct packed {
        logic valid;
        logic degen;
        t_vec sin_v;
        t_vec cos_v;
    } t_sincos;

    // merged basis, right y is always zero and not carried
    typedef struct packed {
        logic valid;
        logic degen;
        t_vec front_x;
        t_vec front_y;
        t_vec front_z;
        t_vec right_x;
        t_vec right_z;
        t_vec up_x;
        t_vec up_y;
        t_vec up_z;
    } t_basis;

    // cordic q30 to vector format, round half up then clamp to unit
    function automatic t_vec f_round_cordic(input logic signed [CW-1:0] x);
        logic signed [CW:0] w;
        w = ((CW+1)'(x) + (CW+1)'(CORDIC_RND)) >>> CORDIC_SH;
        if (w > (CW+1)'(VEC_ONE)) begin
            w = (CW+1)'(VEC_ONE);
        end else if (w < -((CW+1)'(VEC_ONE))) begin
            w = -((CW+1)'(VEC_ONE));
        end
        return t_vec'(w);
    endfunction

    // product back to vector format, round half up then clamp to unit
    function automatic t_vec f_round_prod(input t_prod p);
        t_prod w;
        w = (p + t_prod'(PROD_RND)) >>> VEC_FRAC_BITS;
        if (w > t_prod'(VEC_ONE)) begin
            w = t_prod'(VEC_ONE);
        end else if (w < -(t_prod'(VEC_ONE))) begin
            w = -(t_prod'(VEC_ONE));
        end
        return t_vec'(w);
    endfunction

endpackage

// File: rtl/ypcb_lane.sv
`timescale 1ns / 1ps
// ypcb_lane: one sine/cosine lane, turn and quadrant reduction then pipelined cordic
// depends on ypcb_pkg

module ypcb_lane
    import ypcb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output t_sincos                   o_res
);

    localparam int DEPTH = CORDIC_ITERS;

    // turn reduction
    logic                      r_va;
    logic [TURN_W-1:0]         r_turn;
    logic signed [SHIFT_W:0]   n_shifted;
    logic [SHIFT_W-1:0]        n_pos;
    logic [SHIFT_W-1:0]        n_sel;
    logic [TURN_W-1:0]         n_turn;

    always_comb begin
        n_shifted = (SHIFT_W+1)'(i_angle) + (SHIFT_W+1)'(OFS_TURNS * FULL_TURN);
        n_pos     = n_shifted[SHIFT_W-1:0];
        n_sel     = '0;
        for (int k = 1; k <= MAX_TURNS; k++) begin
            if (n_pos >= SHIFT_W'(k * FULL_TURN)) begin
                n_sel = SHIFT_W'(k * FULL_TURN);
            end
        end
        n_turn = TURN_W'(n_pos - n_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_turn <= n_turn;
    end

    // quadrant split and cordic seed
    logic                    r_vld [0:DEPTH];
    logic signed [CW-1:0]    r_x   [0:DEPTH];
    logic signed [CW-1:0]    r_y   [0:DEPTH];
    logic signed [CW-1:0]    r_z   [0:DEPTH];
    logic [QUAD_W-1:0]       r_q   [0:DEPTH];
    logic                    r_tz  [0:DEPTH];

    logic [QUAD_W-1:0]       n_q;
    logic [TURN_W-1:0]       n_base;
    logic [QTR_W-1:0]        n_t;
    logic signed [CW-1:0]    n_z0;

    always_comb begin
        n_q    = QUAD_0;
        n_base = '0;
        for (int k = 1; k < 4; k++) begin
            if (r_turn >= TURN_W'(k * QUARTER_TURN)) begin
                n_q    = QUAD_W'(k);
                n_base = TURN_W'(k * QUARTER_TURN);
            end
        end
        n_t  = QTR_W'(r_turn - n_base);
        n_z0 = signed'(CW'(n_t) << (CORDIC_ZFRAC - ANGLE_FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_va;
        end
        r_x[0]  <= CORDIC_GAIN_Q30;
        r_y[0]  <= '0;
        r_z[0]  <= n_z0;
        r_q[0]  <= n_q;
        r_tz[0] <= (n_t == '0);
    end

    // one rotation per stage
    for (genvar i = 0; i < DEPTH; i++) begin : g_rot
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            if (!r_z[i][CW-1]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - ATAN_DEG_Q24[i];
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + ATAN_DEG_Q24[i];
            end
            r_q[i+1]  <= r_q[i];
            r_tz[i+1] <= r_tz[i];
        end
    end

    // rounding and quadrant mapping
    t_vec    n_s;
    t_vec    n_c;
    t_sincos n_res;
    t_sincos r_res;

    always_comb begin
        n_s = f_round_cordic(r_y[DEPTH]);
        n_c = f_round_cordic(r_x[DEPTH]);
        if (r_tz[DEPTH]) begin
            n_s = '0;
            n_c = VEC_ONE;
        end
        n_res.valid = r_vld[DEPTH];
        n_res.degen = r_tz[DEPTH] & r_q[DEPTH][0];
        case (r_q[DEPTH])
            QUAD_0: begin
                n_res.sin_v = n_s;
                n_res.cos_v = n_c;
            end
            QUAD_1: begin
                n_res.sin_v = n_c;
                n_res.cos_v = -n_s;
            end
            QUAD_2: begin
                n_res.sin_v = -n_s;
                n_res.cos_v = -n_c;
            end
            default: begin
                n_res.sin_v = -n_c;
                n_res.cos_v = n_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= n_res.valid;
        end
        r_res.degen <= n_res.degen;
        r_res.sin_v <= n_res.sin_v;
        r_res.cos_v <= n_res.cos_v;
    end

    assign o_res = r_res;

endmodule

// File: rtl/ypcb_merge.sv
`timescale 1ns / 1ps
// ypcb_merge: combines yaw and pitch lanes into front, right and up vectors
// depends on ypcb_pkg

module ypcb_merge
    import ypcb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sincos i_yaw,
    input  t_sincos i_pitch,
    output t_basis  o_basis
);

    // products, registered raw
    logic  r_valid;
    logic  r_degen;
    t_vec  r_sy;
    t_vec  r_cy;
    t_vec  r_sp;
    t_vec  r_cp;
    t_prod r_cycp;
    t_prod r_sycp;
    t_prod r_cysp;
    t_prod r_sysp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_yaw.valid;
        end
        r_degen <= i_pitch.degen;
        r_sy    <= i_yaw.sin_v;
        r_cy    <= i_yaw.cos_v;
        r_sp    <= i_pitch.sin_v;
        r_cp    <= i_pitch.cos_v;
        r_cycp  <= t_prod'(i_yaw.cos_v) * t_prod'(i_pitch.cos_v);
        r_sycp  <= t_prod'(i_yaw.sin_v) * t_prod'(i_pitch.cos_v);
        r_cysp  <= t_prod'(i_yaw.cos_v) * t_prod'(i_pitch.sin_v);
        r_sysp  <= t_prod'(i_yaw.sin_v) * t_prod'(i_pitch.sin_v);
    end

    // rounding, sign flip past the pole, degenerate blanking
    t_basis n_basis;
    t_basis r_basis;

    always_comb begin
        n_basis.valid   = r_valid;
        n_basis.degen   = r_degen;
        n_basis.front_x = f_round_prod(r_cycp);
        n_basis.front_y = r_sp;
        n_basis.front_z = f_round_prod(r_sycp);
        n_basis.right_x = -r_sy;
        n_basis.right_z = r_cy;
        n_basis.up_x    = -f_round_prod(r_cysp);
        n_basis.up_y    = r_cp;
        n_basis.up_z    = -f_round_prod(r_sysp);
        if (r_cp[VEC_W-1]) begin
            n_basis.right_x = -n_basis.right_x;
            n_basis.right_z = -n_basis.right_z;
            n_basis.up_x    = -n_basis.up_x;
            n_basis.up_y    = -n_basis.up_y;
            n_basis.up_z    = -n_basis.up_z;
        end
        if (r_degen) begin
            n_basis.right_x = '0;
            n_basis.right_z = '0;
            n_basis.up_x    = '0;
            n_basis.up_y    = '0;
            n_basis.up_z    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis.valid <= 1'b0;
        end else begin
            r_basis.valid <= n_basis.valid;
        end
        r_basis.degen   <= n_basis.degen;
        r_basis.front_x <= n_basis.front_x;
        r_basis.front_y <= n_basis.front_y;
        r_basis.front_z <= n_basis.front_z;
        r_basis.right_x <= n_basis.right_x;
        r_basis.right_z <= n_basis.right_z;
        r_basis.up_x    <= n_basis.up_x;
        r_basis.up_y    <= n_basis.up_y;
        r_basis.up_z    <= n_basis.up_z;
    end

    assign o_basis = r_basis;

endmodule

// File: rtl/yaw_pitch_camera_basis.sv
`timescale 1ns / 1ps
// yaw_pitch_camera_basis: camera front, right and up vectors from yaw and pitch
// depends on ypcb_pkg, ypcb_lane and ypcb_merge
//
// channel   direction  handshake            payload
// --------  ---------  -------------------  ------------------------------------------
// command   in         start high, busy low i_yaw_angle, i_pitch_angle
// result    out        o_done, one cycle    o_front_*, o_right_*, o_up_*, o_degenerate
//
// one beat is taken every clock cycle; busy stays low as the pipeline never holds
// o_done pulses once the beat has passed two reduction stages, the
// 24 cordic stages of each lane, one rounding stage, one multiply and one merge stage
// reset is synchronous and active low; it clears only the valid line of the pipeline
// the receiver cannot stall, so each result is on the ports for exactly one cycle

module yaw_pitch_camera_basis
    import ypcb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [ANGLE_W-1:0] i_yaw_angle,
    input  logic signed [14:0]        i_pitch_angle,
    output logic                      o_done,
    output logic signed [FIELD_W-1:0] o_front_x,
    output logic signed [FIELD_W-1:0] o_front_y,
    output logic signed [FIELD_W-1:0] o_front_z,
    output logic signed [FIELD_W-1:0] o_right_x,
    output logic signed [FIELD_W-1:0] o_right_y,
    output logic signed [FIELD_W-1:0] o_right_z,
    output logic signed [FIELD_W-1:0] o_up_x,
    output logic signed [FIELD_W-1:0] o_up_y,
    output logic signed [FIELD_W-1:0] o_up_z,
    output logic                      o_degenerate
);

    logic    take;
    t_sincos yaw_sc;
    t_sincos pitch_sc;
    t_basis  basis;

    // fully pipelined, a command beat is always taken
    assign busy = 1'b0;
    assign take = start & ~busy;

    // yaw lane
    ypcb_lane u_yaw_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_angle (i_yaw_angle),
        .o_res   (yaw_sc)
    );

    // pitch lane, pitch sign extended to the common angle width
    ypcb_lane u_pitch_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_angle (ANGLE_W'(i_pitch_angle)),
        .o_res   (pitch_sc)
    );

    // products, pole handling and output register
    ypcb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_yaw   (yaw_sc),
        .i_pitch (pitch_sc),
        .o_basis (basis)
    );

    // vector fields go out as 16-bit two's complement
    assign o_done       = basis.valid;
    assign o_degenerate = basis.degen;
    assign o_front_x    = FIELD_W'(basis.front_x);
    assign o_front_y    = FIELD_W'(basis.front_y);
    assign o_front_z    = FIELD_W'(basis.front_z);
    assign o_right_x    = FIELD_W'(basis.right_x);
    assign o_right_y    = '0;
    assign o_right_z    = FIELD_W'(basis.right_z);
    assign o_up_x       = FIELD_W'(basis.up_x);
    assign o_up_y       = FIELD_W'(basis.up_y);
    assign o_up_z       = FIELD_W'(basis.up_z);

endmodule
